// ===== rtl/core/gzhp_pkg.sv =====
// gzhp_pkg: word types, parse phase encoding and header constants for the
// gzip member header parser. No dependencies; used by gzhp_parse and the core.
`default_nettype none

package gzhp_pkg;

   typedef enum logic [2:0] {
      KIND_HEADER   = 3'd0,
      KIND_DONE     = 3'd1,
      KIND_PAYLOAD  = 3'd2,
      KIND_BADMAGIC = 3'd3,
      KIND_BADMETH  = 3'd4,
      KIND_TRUNC    = 3'd5
   } kind_type;

   typedef enum logic [14:0] {
      PH_MAGIC0     = 15'h0001,
      PH_MAGIC1     = 15'h0002,
      PH_METHOD     = 15'h0004,
      PH_FLAGS      = 15'h0008,
      PH_FIXED      = 15'h0010,
      PH_XLEN0      = 15'h0020,
      PH_XLEN1      = 15'h0040,
      PH_EXTRA      = 15'h0080,
      PH_NAME       = 15'h0100,
      PH_COMMENT    = 15'h0200,
      PH_HCRC       = 15'h0400,
      PH_PAYLOAD    = 15'h0800,
      PH_ERR_MAGIC  = 15'h1000,
      PH_ERR_METHOD = 15'h2000,
      PH_ERR_TRUNC  = 15'h4000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_start;
      logic       stream_end;
   } req_word_type;

   typedef struct packed {
      kind_type   byte_kind;
      logic [7:0] payload_byte;
      logic [7:0] header_flags;
   } rsp_word_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] count;
      logic [7:0]  flags;
   } parse_state_type;

   localparam logic [7:0]  MAGIC_ID1     = 8'h1f;
   localparam logic [7:0]  MAGIC_ID2     = 8'h8b;
   localparam logic [7:0]  MAGIC_ID2_OLD = 8'h9e;
   localparam logic [7:0]  CM_DEFLATE    = 8'd8;
   localparam logic [7:0]  STR_TERM      = 8'h00;
   localparam logic [16:0] FIXED_LEN     = 17'd6;
   localparam logic [16:0] HCRC_LEN      = 17'd2;

   localparam int FLG_HCRC_BIT    = 1;
   localparam int FLG_EXTRA_BIT   = 2;
   localparam int FLG_NAME_BIT    = 3;
   localparam int FLG_COMMENT_BIT = 4;

   localparam logic [1:0] SEC_EXTRA   = 2'd0;
   localparam logic [1:0] SEC_NAME    = 2'd1;
   localparam logic [1:0] SEC_COMMENT = 2'd2;
   localparam logic [1:0] SEC_HCRC    = 2'd3;

   // first optional section at or after from_sel that the flags enable
   function automatic phase_type next_section(input logic [1:0] from_sel,
                                              input logic [7:0] flg);
      phase_type ph;
      if (from_sel == SEC_EXTRA && flg[FLG_EXTRA_BIT]) begin
         ph = PH_XLEN0;
      end else if ((from_sel == SEC_EXTRA || from_sel == SEC_NAME) &&
                   flg[FLG_NAME_BIT]) begin
         ph = PH_NAME;
      end else if (from_sel != SEC_HCRC && flg[FLG_COMMENT_BIT]) begin
         ph = PH_COMMENT;
      end else if (flg[FLG_HCRC_BIT]) begin
         ph = PH_HCRC;
      end else begin
         ph = PH_PAYLOAD;
      end
      return ph;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gzip_header_parser_core.sv =====
// gzip_header_parser_core: gzip member header parser top level, input word
// register, parse state and result register. Depends on gzhp_pkg, gzhp_parse.
//
//   port group   dir  payload         notes
//   req_*        in   req_word_type   one stream byte per word
//   rsp_*        out  rsp_word_type   one classification per input word
//
// One word per cycle unless rsp_stall holds; a word is staged, then registered out.
// The parse state advances when the staged input word moves into the result
// register, so throughput is set by that single state update per cycle.
// Synchronous reset clears both valid flags and returns the parser to the
// first magic byte. rsp_stall holds the result; the input stage keeps taking
// a word while it has room, then req_stall rises.
`default_nettype none

module gzip_header_parser_core
   import gzhp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire req_word_type req_word,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      rsp_word_type rsp_word
);

   logic            s1_valid_ff;
   logic            s1_valid_in;
   req_word_type    s1_word_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_word_type    rsp_word_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   rsp_word_type    step_rsp;
   logic            advance;
   logic            s1_load;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign s1_load      = req_valid && !req_stall;
   assign s1_valid_in  = s1_load || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   gzhp_parse u_parse (
      .word (s1_word_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .rsp  (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff.phase <= PH_MAGIC0;
         state_ff.count <= 16'd0;
         state_ff.flags <= 8'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff.phase == PH_ERR_MAGIC && !s1_word_ff.stream_start)
      |=> state_ff.phase == PH_ERR_MAGIC)
      else $error("magic error state left without restart");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("parse state changed without a word moving");

   a_pay_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.byte_kind != KIND_PAYLOAD)
      |-> rsp_word_ff.payload_byte == 8'd0)
      else $error("payload byte set on a non-payload word");

   a_magic_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.byte_kind == KIND_BADMAGIC)
      |-> rsp_word_ff.header_flags == 8'd0)
      else $error("flags captured before magic check passed");

   a_req_room: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("input stalled with empty input stage");

endmodule

`default_nettype wire

// ===== rtl/core/gzhp_parse.sv =====
// gzhp_parse: one header parse step, current state and input word to next
// state and result word. Purely combinational. Depends on gzhp_pkg.
`default_nettype none

module gzhp_parse
   import gzhp_pkg::*;
(
   input  req_word_type    word,
   input  parse_state_type cur,
   output parse_state_type nxt,
   output rsp_word_type    rsp
);

   phase_type   ph;
   logic [15:0] cnt;
   logic [7:0]  flg;
   logic [7:0]  b;
   logic        in_header;
   logic [16:0] cnt_inc;
   logic [15:0] cnt_dec;
   logic [15:0] xlen;
   phase_type   n_ph;
   logic [15:0] n_cnt;
   logic [7:0]  n_flg;
   kind_type    kind;
   logic [7:0]  pay;

   assign b       = word.data_byte;
   assign ph      = word.stream_start ? PH_MAGIC0 : cur.phase;
   assign cnt     = word.stream_start ? 16'd0 : cur.count;
   assign flg     = word.stream_start ? 8'd0 : cur.flags;
   assign cnt_inc = {1'b0, cnt} + 17'd1;
   assign cnt_dec = cnt - 16'd1;
   assign xlen    = cnt | {b, 8'h00};

   always_comb begin
      n_ph  = ph;
      n_cnt = cnt;
      n_flg = flg;
      kind  = KIND_HEADER;
      pay   = 8'd0;
      in_header = 1'b1;
      case (ph)
         PH_MAGIC0: begin
            if (b == MAGIC_ID1) begin
               n_ph = PH_MAGIC1;
            end else begin
               n_ph = PH_ERR_MAGIC;
               kind = KIND_BADMAGIC;
            end
         end
         PH_MAGIC1: begin
            if (b == MAGIC_ID2 || b == MAGIC_ID2_OLD) begin
               n_ph = PH_METHOD;
            end else begin
               n_ph = PH_ERR_MAGIC;
               kind = KIND_BADMAGIC;
            end
         end
         PH_METHOD: begin
            if (b == CM_DEFLATE) begin
               n_ph = PH_FLAGS;
            end else begin
               n_ph = PH_ERR_METHOD;
               kind = KIND_BADMETH;
            end
         end
         PH_FLAGS: begin
            n_flg = b;
            n_cnt = 16'd0;
            n_ph  = PH_FIXED;
         end
         PH_FIXED: begin
            n_cnt = cnt_inc[15:0];
            if (cnt_inc >= FIXED_LEN) begin
               n_cnt = 16'd0;
               n_ph  = next_section(SEC_EXTRA, flg);
            end
         end
         PH_XLEN0: begin
            n_cnt = {8'd0, b};
            n_ph  = PH_XLEN1;
         end
         PH_XLEN1: begin
            n_cnt = xlen;
            n_ph  = (xlen == 16'd0) ? next_section(SEC_NAME, flg) : PH_EXTRA;
         end
         PH_EXTRA: begin
            n_cnt = cnt_dec;
            if (cnt_dec == 16'd0) begin
               n_ph = next_section(SEC_NAME, flg);
            end
         end
         PH_NAME: begin
            if (b == STR_TERM) begin
               n_ph = next_section(SEC_COMMENT, flg);
            end
         end
         PH_COMMENT: begin
            if (b == STR_TERM) begin
               n_ph = next_section(SEC_HCRC, flg);
            end
         end
         PH_HCRC: begin
            n_cnt = cnt_inc[15:0];
            if (cnt_inc >= HCRC_LEN) begin
               n_cnt = 16'd0;
               n_ph  = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            in_header = 1'b0;
            kind      = KIND_PAYLOAD;
            pay       = b;
         end
         PH_ERR_MAGIC: begin
            in_header = 1'b0;
            kind      = KIND_BADMAGIC;
         end
         PH_ERR_METHOD: begin
            in_header = 1'b0;
            kind      = KIND_BADMETH;
         end
         default: begin
            in_header = 1'b0;
            n_ph      = PH_ERR_TRUNC;
            kind      = KIND_TRUNC;
         end
      endcase

      if (in_header && kind == KIND_HEADER) begin
         if (n_ph == PH_PAYLOAD) begin
            kind = KIND_DONE;
         end else if (word.stream_end) begin
            n_ph  = PH_ERR_TRUNC;
            n_cnt = 16'd0;
            kind  = KIND_TRUNC;
         end
      end
   end

   assign nxt.phase        = n_ph;
   assign nxt.count        = n_cnt;
   assign nxt.flags        = n_flg;
   assign rsp.byte_kind    = kind;
   assign rsp.payload_byte = pay;
   assign rsp.header_flags = n_flg;

endmodule

`default_nettype wire

// ===== tb/gzip_header_parser_core_check.sv =====
// Checker for gzip_header_parser_core: watches both channels, predicts the
// classification of each accepted byte and compares it with the result word.
// Depends on gzhp_pkg for the word types, phase encoding and header constants.
`timescale 1ns / 100ps

module gzip_header_parser_core_check
   import gzhp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire req_word_type req_word,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire rsp_word_type rsp_word,
   output      int           fail_count,
   output      int           pending_count
);

   phase_type    phase = PH_MAGIC0;
   logic [15:0]  count = '0;
   logic [7:0]   flags = '0;
   rsp_word_type expected_kinds[$];
   int           mismatches = 0;

   function automatic phase_type section_after(input logic [1:0] from);
      phase_type ph;
      if (from <= SEC_EXTRA && flags[FLG_EXTRA_BIT]) begin
         ph = PH_XLEN0;
      end else if (from <= SEC_NAME && flags[FLG_NAME_BIT]) begin
         ph = PH_NAME;
      end else if (from <= SEC_COMMENT && flags[FLG_COMMENT_BIT]) begin
         ph = PH_COMMENT;
      end else if (flags[FLG_HCRC_BIT]) begin
         ph = PH_HCRC;
      end else begin
         ph = PH_PAYLOAD;
      end
      return ph;
   endfunction

   function automatic rsp_word_type classify_byte(input req_word_type w);
      rsp_word_type r;
      logic         in_hdr;
      logic [7:0]   b;
      b = w.data_byte;
      r.byte_kind = KIND_HEADER;
      r.payload_byte = 8'h00;
      if (w.stream_start) begin
         phase = PH_MAGIC0;
         count = '0;
         flags = '0;
      end
      in_hdr = phase != PH_PAYLOAD && phase != PH_ERR_MAGIC &&
               phase != PH_ERR_METHOD && phase != PH_ERR_TRUNC;
      case (phase)
         PH_MAGIC0: begin
            if (b == MAGIC_ID1) begin
               phase = PH_MAGIC1;
            end else begin
               phase = PH_ERR_MAGIC;
               r.byte_kind = KIND_BADMAGIC;
            end
         end
         PH_MAGIC1: begin
            if (b == MAGIC_ID2 || b == MAGIC_ID2_OLD) begin
               phase = PH_METHOD;
            end else begin
               phase = PH_ERR_MAGIC;
               r.byte_kind = KIND_BADMAGIC;
            end
         end
         PH_METHOD: begin
            if (b == CM_DEFLATE) begin
               phase = PH_FLAGS;
            end else begin
               phase = PH_ERR_METHOD;
               r.byte_kind = KIND_BADMETH;
            end
         end
         PH_FLAGS: begin
            flags = b;
            count = '0;
            phase = PH_FIXED;
         end
         PH_FIXED: begin
            count = count + 16'd1;
            if (count >= FIXED_LEN[15:0]) begin
               count = '0;
               phase = section_after(SEC_EXTRA);
            end
         end
         PH_XLEN0: begin
            count = {8'h00, b};
            phase = PH_XLEN1;
         end
         PH_XLEN1: begin
            count = count | {b, 8'h00};
            phase = (count == 16'd0) ? section_after(SEC_NAME) : PH_EXTRA;
         end
         PH_EXTRA: begin
            count = count - 16'd1;
            if (count == 16'd0) begin
               phase = section_after(SEC_NAME);
            end
         end
         PH_NAME: begin
            if (b == STR_TERM) begin
               phase = section_after(SEC_COMMENT);
            end
         end
         PH_COMMENT: begin
            if (b == STR_TERM) begin
               phase = section_after(SEC_HCRC);
            end
         end
         PH_HCRC: begin
            count = count + 16'd1;
            if (count >= HCRC_LEN[15:0]) begin
               count = '0;
               phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            r.byte_kind = KIND_PAYLOAD;
            r.payload_byte = b;
         end
         PH_ERR_MAGIC: begin
            r.byte_kind = KIND_BADMAGIC;
         end
         PH_ERR_METHOD: begin
            r.byte_kind = KIND_BADMETH;
         end
         default: begin
            phase = PH_ERR_TRUNC;
            r.byte_kind = KIND_TRUNC;
         end
      endcase
      if (in_hdr && r.byte_kind == KIND_HEADER) begin
         if (phase == PH_PAYLOAD) begin
            r.byte_kind = KIND_DONE;
         end else if (w.stream_end) begin
            phase = PH_ERR_TRUNC;
            count = '0;
            r.byte_kind = KIND_TRUNC;
         end
      end
      r.header_flags = flags;
      return r;
   endfunction

   function automatic void report(input string what, input rsp_word_type want);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: kind %0d/%0d payload %h/%h flags %h/%h", $realtime, what,
                  want.byte_kind, rsp_word.byte_kind, want.payload_byte,
                  rsp_word.payload_byte, want.header_flags, rsp_word.header_flags);
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         phase = PH_MAGIC0;
         count = '0;
         flags = '0;
         expected_kinds.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_kinds.size() == 0) begin
               want = '0;
               report("unexpected word (exp/act)", want);
            end else begin
               want = expected_kinds.pop_front();
               if (rsp_word.byte_kind !== want.byte_kind ||
                   rsp_word.payload_byte !== want.payload_byte ||
                   rsp_word.header_flags !== want.header_flags) begin
                  report("mismatch (exp/act)", want);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_kinds.push_back(classify_byte(req_word));
         end
      end
      fail_count <= mismatches;
      pending_count <= expected_kinds.size();
   end

endmodule

// ===== tb/gzip_header_parser_core_test.sv =====
// Testbench top for gzip_header_parser_core: clock, reset, byte stimulus with
// random idling and back-pressure, verdict. Depends on gzhp_pkg, the core and
// gzip_header_parser_core_check.
`timescale 1ns / 100ps

module gzip_header_parser_core_test;
   import gzhp_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   int           fail_count;
   int           pending_count;

   bit           calm = 1'b0;
   bit           hold_pending = 1'b0;
   int           sent = 0;
   req_word_type member_q[$];

   always #5 clock = ~clock;

   gzip_header_parser_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   gzip_header_parser_core_check i_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   task automatic push_byte(input logic [7:0] b, input logic s, input logic e);
      req_word_type w;
      w.data_byte = b;
      w.stream_start = s;
      w.stream_end = e;
      member_q.push_back(w);
   endtask

   task automatic send_word(input req_word_type w);
      while (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic send_member();
      while (member_q.size() != 0) begin
         calm = sent >= 400 && sent < 700;
         send_word(member_q.pop_front());
         sent++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   // receiver: random stall, plus one long hold-off on request
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && $urandom_range(99) < 38;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [7:0]   flg;
      int           xlen;
      int           n;
      int           i;
      bit           held;
      bit           paused;
      req_word_type w;
      held = 1'b0;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // all flags, old magic, zero extra length, empty strings, end in payload
      push_byte(MAGIC_ID1, 1'b1, 1'b0);
      push_byte(MAGIC_ID2_OLD, 1'b0, 1'b0);
      push_byte(CM_DEFLATE, 1'b0, 1'b0);
      push_byte(8'hff, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hff, 1'b0, 1'b0);
      push_byte(8'h55, 1'b0, 1'b0);
      push_byte(8'haa, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hff, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(STR_TERM, 1'b0, 1'b0);
      push_byte(STR_TERM, 1'b0, 1'b0);
      push_byte(8'hff, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hab, 1'b0, 1'b1);
      push_byte(8'h00, 1'b0, 1'b0);
      // bad first magic, held error
      push_byte(8'h00, 1'b1, 1'b0);
      push_byte(MAGIC_ID1, 1'b0, 1'b0);
      // bad second magic
      push_byte(MAGIC_ID1, 1'b1, 1'b0);
      push_byte(8'h8a, 1'b0, 1'b0);
      // bad method
      push_byte(MAGIC_ID1, 1'b1, 1'b0);
      push_byte(MAGIC_ID2, 1'b0, 1'b0);
      push_byte(8'h07, 1'b0, 1'b0);
      // truncated header, held
      push_byte(MAGIC_ID1, 1'b1, 1'b0);
      push_byte(MAGIC_ID2, 1'b0, 1'b1);
      push_byte(CM_DEFLATE, 1'b0, 1'b0);
      send_member();

      while (sent < 1300) begin
         if (!held && sent >= 200) begin
            held = 1'b1;
            hold_pending = 1'b1;
         end
         if (!paused && sent >= 800) begin
            paused = 1'b1;
            drain();
         end

         flg = 8'($urandom_range(255));
         push_byte(MAGIC_ID1, 1'b1, 1'b0);
         push_byte($urandom_range(1) ? MAGIC_ID2 : MAGIC_ID2_OLD, 1'b0, 1'b0);
         push_byte(CM_DEFLATE, 1'b0, 1'b0);
         push_byte(flg, 1'b0, 1'b0);
         repeat (6) push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
         if (flg[FLG_EXTRA_BIT]) begin
            xlen = ($urandom_range(39) == 0) ? $urandom_range(300, 256) : $urandom_range(6);
            push_byte(xlen[7:0], 1'b0, 1'b0);
            push_byte(xlen[15:8], 1'b0, 1'b0);
            repeat (xlen) push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
         end
         if (flg[FLG_NAME_BIT]) begin
            repeat ($urandom_range(5)) push_byte(8'($urandom_range(255, 1)), 1'b0, 1'b0);
            push_byte(STR_TERM, 1'b0, 1'b0);
         end
         if (flg[FLG_COMMENT_BIT]) begin
            repeat ($urandom_range(5)) push_byte(8'($urandom_range(255, 1)), 1'b0, 1'b0);
            push_byte(STR_TERM, 1'b0, 1'b0);
         end
         if (flg[FLG_HCRC_BIT]) begin
            repeat (2) push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
         end
         n = $urandom_range(6);
         for (int k = 0; k < n; k++) begin
            push_byte(8'($urandom_range(255)), 1'b0,
                      k == n - 1 && $urandom_range(1) == 1);
         end

         // broken members: corrupt byte, early end, restart, or plain noise
         if ($urandom_range(99) < 20) begin
            i = $urandom_range(member_q.size() - 1);
            w = member_q[i];
            case ($urandom_range(3))
               0: begin
                  w.data_byte = 8'($urandom_range(255));
                  member_q[i] = w;
               end
               1: begin
                  w.stream_end = 1'b1;
                  member_q[i] = w;
                  while (member_q.size() > i + 3) begin
                     w = member_q.pop_back();
                  end
               end
               2: begin
                  w.stream_start = 1'b1;
                  member_q[i] = w;
               end
               default: begin
                  member_q.delete();
                  repeat ($urandom_range(5, 1)) begin
                     push_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                               1'($urandom_range(1)));
                  end
               end
            endcase
         end
         send_member();
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
